// File: rtl/assert_macros.svh
// assertion macros shared by the front, queue and back modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clk edge, off while rst_n is low
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// condition that must never be true at a clk edge out of reset
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

// File: rtl/jpdst_pkg.sv
// types, constants and the sine table function of the joint pd controller
package jpdst_pkg;

    localparam int JOINTS          = 32;
    localparam int JOINT_ADDR_BITS = $clog2(JOINTS);
    localparam int SINE_TABLE_BITS = 8;
    localparam int SINE_QBITS      = SINE_TABLE_BITS - 2;
    localparam int SINE_QUARTER    = 1 << SINE_QBITS;
    localparam int SINE_M_BITS     = SINE_QBITS + 1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCOUNT_BITS = $clog2(QUEUE_DEPTH + 1);

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    localparam logic signed [31:0] TORQUE_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] TORQUE_MIN = 32'sh8000_0000;

    // configuration register indexes
    localparam int CFG_INDEX_BITS = 3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_P_GAIN          = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_D_GAIN_PER_STEP = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PHASE_STEP      = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_AMPLITUDE       = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DEADZONE        = 3'd4;

    localparam logic [23:0] P_GAIN_RESET          = 24'd51200;
    localparam logic [31:0] D_GAIN_PER_STEP_RESET = 32'd7680000;
    localparam logic [31:0] PHASE_STEP_RESET      = 32'd2147484;
    localparam logic [30:0] AMPLITUDE_RESET       = 31'd655360;
    localparam logic [14:0] DEADZONE_RESET        = 15'd6554;

    localparam logic ACTION_CAPTURE = 1'b0;
    localparam logic ACTION_CONTROL = 1'b1;

    typedef struct packed {
        logic               action;
        logic [4:0]         joint_index;
        logic signed [31:0] position;
        logic signed [15:0] axis_value;
    } sample_t;

    typedef struct packed {
        logic signed [31:0] torque;
        logic               saturated;
    } result_t;

    typedef struct packed {
        logic [23:0] p_gain;
        logic [31:0] d_gain_per_step;
        logic [31:0] phase_step;
        logic [30:0] amplitude;
        logic [14:0] deadzone;
    } cfg_t;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_HOLD,
        OP_DRIVE
    } op_t;

    typedef struct packed {
        op_t                        op;
        logic [JOINT_ADDR_BITS-1:0] joint;
        logic signed [31:0]         position;
        logic [SINE_TABLE_BITS-1:0] sine_index;
    } qentry_t;

    // quarter-wave sine magnitude in q15, evaluated on constant arguments only
    function automatic logic [15:0] sine_mag(input int unsigned m);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic [63:0]        prod;
        logic signed [63:0] acc;
        logic [63:0]        mag;
        int                 n;
        x    = (64'(m) * HALF_PI_Q30) >> SINE_QBITS;
        x2   = (x * x) >> 30;
        term = x;
        acc  = $signed(x);
        for (n = 1; n <= 7; n++)
        begin
            prod = (term * x2) >> 30;
            case (n)
                1:       term = prod / 64'd6;
                2:       term = prod / 64'd20;
                3:       term = prod / 64'd42;
                4:       term = prod / 64'd72;
                5:       term = prod / 64'd110;
                6:       term = prod / 64'd156;
                default: term = prod / 64'd210;
            endcase
            if (n[0])
                acc = acc - $signed(term);
            else
                acc = acc + $signed(term);
        end
        if (acc < 0)
            acc = '0;
        mag = ($unsigned(acc) + 64'd16384) >> 15;
        return mag[15:0];
    endfunction

endpackage

// File: rtl/jpdst_ram.sv
// generic single write, single registered read memory
module jpdst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // read returns the old word when the same address is written
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/jpdst_front.sv
// front end: takes samples, classifies them and advances the sine phase
`include "assert_macros.svh"

module jpdst_front import jpdst_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    sample_valid,
    input  sample_t sample,
    output logic    sample_stall,
    input  logic    queue_full,
    output logic    push,
    output qentry_t push_entry
);

    logic [31:0]        phase_reg;
    logic [31:0]        phase_next;
    logic               in_range;
    logic signed [16:0] axis_ext;
    logic [16:0]        axis_mag;
    logic               active;
    op_t                op;

    assign sample_stall = queue_full;
    assign push         = sample_valid && !queue_full;

    assign in_range   = 32'(sample.joint_index) < 32'(JOINTS);
    assign axis_ext   = {sample.axis_value[15], sample.axis_value};
    assign axis_mag   = axis_ext[16] ? $unsigned(-axis_ext) : $unsigned(axis_ext);
    assign active     = axis_mag > {2'b00, cfg.deadzone};
    assign phase_next = phase_reg + cfg.phase_step;

    always_comb
    begin
        if (!in_range)
            op = OP_NONE;
        else if (sample.action == ACTION_CAPTURE)
            op = OP_CAPTURE;
        else if (sample.joint_index == 5'd0)
            op = active ? OP_DRIVE : OP_NONE;
        else
            op = OP_HOLD;
    end

    always_comb
    begin
        push_entry.op         = op;
        push_entry.joint      = JOINT_ADDR_BITS'(sample.joint_index);
        push_entry.position   = sample.position;
        push_entry.sine_index = phase_next[31 -: SINE_TABLE_BITS];
    end

    // phase moves only on an accepted, active driven-joint item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            phase_reg <= '0;
        else if (push && op == OP_DRIVE)
            phase_reg <= phase_next;
    end

    `ASSERT_CLK(a_phase_only_on_drive, !(push && op == OP_DRIVE) |=> $stable(phase_reg),
        "phase moved without a driven item")

endmodule

// File: rtl/jpdst_queue.sv
// short queue of classified items between front and back
`include "assert_macros.svh"

module jpdst_queue import jpdst_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  qentry_t push_entry,
    output logic    full,
    input  logic    pop,
    output qentry_t head,
    output logic    head_valid
);

    qentry_t                slot_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]   wr_ptr_reg;
    logic [QPTR_BITS-1:0]   wr_ptr_next;
    logic [QPTR_BITS-1:0]   rd_ptr_reg;
    logic [QPTR_BITS-1:0]   rd_ptr_next;
    logic [QCOUNT_BITS-1:0] count_reg;
    logic [QCOUNT_BITS-1:0] count_next;
    logic                   push_ok;

    assign full       = count_reg == QCOUNT_BITS'(QUEUE_DEPTH);
    assign head_valid = count_reg != '0;
    assign head       = slot_reg[rd_ptr_reg];
    assign push_ok    = push && !full;

    assign wr_ptr_next = (wr_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_next = (rd_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;

    always_comb
    begin
        case ({push_ok, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push_ok)
                wr_ptr_reg <= wr_ptr_next;
            if (pop)
                rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
            slot_reg[wr_ptr_reg] <= push_entry;
    end

    `ASSERT_NEVER(a_pop_empty, pop && count_reg == '0, "queue popped while empty")
    `ASSERT_CLK(a_count_bound, count_reg <= QCOUNT_BITS'(QUEUE_DEPTH),
        "queue count beyond depth")

endmodule

// File: rtl/jpdst_back.sv
// back end: per-joint state, sine target and the pd arithmetic pipeline
`include "assert_macros.svh"

module jpdst_back import jpdst_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  qentry_t head,
    input  logic    head_valid,
    output logic    pop,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    localparam logic [SINE_M_BITS-1:0] QUARTER_M = SINE_M_BITS'(SINE_QUARTER);
    localparam logic [58:0] D_CLAMP = 59'd1 << 58;
    localparam logic signed [60:0] SUM_TMAX = 61'sd2147483647;
    localparam logic signed [60:0] SUM_TMIN = -61'sd2147483648;

    logic    adv;
    logic    result_valid_reg;
    result_t result_reg;

    // stage 1: pop, memory access, sine lookup
    logic [15:0]                sine_rom [SINE_QUARTER + 1];
    logic [1:0]                 quad;
    logic [SINE_QBITS-1:0]      quad_pos;
    logic [SINE_M_BITS-1:0]     m;
    logic                       hold_we;
    logic                       prev_we;
    logic [31:0]                hold_rd;
    logic [31:0]                prev_rd;

    for (genvar g = 0; g <= SINE_QUARTER; g++)
    begin : g_sine_rom
        assign sine_rom[g] = sine_mag(g);
    end

    assign adv = !result_valid_reg || !result_stall;
    assign pop = head_valid && adv;

    assign quad     = head.sine_index[SINE_TABLE_BITS-1 -: 2];
    assign quad_pos = head.sine_index[SINE_QBITS-1:0];
    assign m        = quad[0] ? QUARTER_M - {1'b0, quad_pos} : {1'b0, quad_pos};

    assign hold_we = pop && head.op == OP_CAPTURE;
    assign prev_we = pop && head.op != OP_NONE;

    jpdst_ram #(.WIDTH(32), .DEPTH(JOINTS)) u_hold_ram (
        .clk     (clk),
        .wr_en   (hold_we),
        .wr_addr (head.joint),
        .wr_data (head.position),
        .rd_en   (adv),
        .rd_addr (head.joint),
        .rd_data (hold_rd)
    );

    jpdst_ram #(.WIDTH(32), .DEPTH(JOINTS)) u_prev_ram (
        .clk     (clk),
        .wr_en   (prev_we),
        .wr_addr (head.joint),
        .wr_data (head.position),
        .rd_en   (adv),
        .rd_addr (head.joint),
        .rd_data (prev_rd)
    );

    logic               s2_valid_reg;
    op_t                s2_op_reg;
    logic signed [31:0] s2_pos_reg;
    logic [15:0]        s2_mag_reg;
    logic               s2_neg_reg;

    // stage 2: amplitude times sine
    logic [46:0]        prod;
    logic               s3_valid_reg;
    op_t                s3_op_reg;
    logic signed [31:0] s3_pos_reg;
    logic [46:0]        s3_prod_reg;
    logic               s3_neg_reg;
    logic [31:0]        s3_hold_reg;
    logic [31:0]        s3_prev_reg;

    assign prod = 47'(cfg.amplitude) * 47'(s2_mag_reg);

    // stage 3: target, position error and change
    logic [46:0]        rounded;
    logic [31:0]        tm;
    logic signed [31:0] target;
    logic signed [32:0] err;
    logic signed [32:0] dq;
    logic [32:0]        am;
    logic               s4_valid_reg;
    op_t                s4_op_reg;
    logic signed [32:0] s4_err_reg;
    logic [32:0]        s4_am_reg;
    logic               s4_dneg_reg;

    always_comb
    begin
        rounded = s3_prod_reg + 47'd16384;
        tm      = rounded[46:15];
        if (s3_op_reg == OP_DRIVE)
            target = s3_neg_reg ? -$signed(tm) : $signed(tm);
        else
            target = $signed(s3_hold_reg);
        err = $signed({target[31], target}) - $signed({s3_pos_reg[31], s3_pos_reg});
        dq  = $signed({s3_pos_reg[31], s3_pos_reg})
              - $signed({s3_prev_reg[31], s3_prev_reg});
        am  = dq[32] ? $unsigned(-dq) : $unsigned(dq);
    end

    // stage 4: gain products, d gain split in two 16-bit halves
    logic signed [57:0] pe;
    logic [48:0]        d_hi;
    logic [48:0]        d_lo;
    logic               s5_valid_reg;
    op_t                s5_op_reg;
    logic signed [57:0] s5_pe_reg;
    logic [48:0]        s5_hi_reg;
    logic [48:0]        s5_lo_reg;
    logic               s5_dneg_reg;

    assign pe   = $signed({1'b0, cfg.p_gain}) * s4_err_reg;
    assign d_hi = 49'(s4_am_reg) * 49'(cfg.d_gain_per_step[31:16]);
    assign d_lo = 49'(s4_am_reg) * 49'(cfg.d_gain_per_step[15:0]);

    // stage 5: d magnitude with clamp
    logic [58:0]        d_wide;
    logic [58:0]        dmag;
    logic               s6_valid_reg;
    op_t                s6_op_reg;
    logic signed [57:0] s6_pe_reg;
    logic [58:0]        s6_dmag_reg;
    logic               s6_dneg_reg;

    assign d_wide = 59'({s5_hi_reg[41:0], 16'b0}) + 59'(s5_lo_reg);
    assign dmag   = (s5_hi_reg[48:42] != '0 || d_wide > D_CLAMP) ? D_CLAMP : d_wide;

    // stage 6: pd sum
    logic signed [60:0] pe_ext;
    logic signed [60:0] d_ext;
    logic signed [60:0] pd_sum;
    logic               s7_valid_reg;
    op_t                s7_op_reg;
    logic signed [60:0] s7_sum_reg;

    assign pe_ext = 61'(s6_pe_reg);
    assign d_ext  = $signed({2'b00, s6_dmag_reg});
    assign pd_sum = s6_dneg_reg ? pe_ext + d_ext : pe_ext - d_ext;

    // stage 7: divide by 256 toward zero and saturate; other ops give zero torque
    logic signed [60:0] biased;
    logic signed [60:0] scaled;
    result_t            res;

    always_comb
    begin
        biased = s7_sum_reg + (s7_sum_reg[60] ? 61'sd255 : 61'sd0);
        scaled = biased >>> 8;
        res.torque    = '0;
        res.saturated = 1'b0;
        if (s7_op_reg == OP_HOLD || s7_op_reg == OP_DRIVE)
        begin
            if (scaled > SUM_TMAX)
            begin
                res.torque    = TORQUE_MAX;
                res.saturated = 1'b1;
            end
            else if (scaled < SUM_TMIN)
            begin
                res.torque    = TORQUE_MIN;
                res.saturated = 1'b1;
            end
            else
                res.torque = scaled[31:0];
        end
    end

    // the whole pipe advances together unless the output is held
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg     <= 1'b0;
            s3_valid_reg     <= 1'b0;
            s4_valid_reg     <= 1'b0;
            s5_valid_reg     <= 1'b0;
            s6_valid_reg     <= 1'b0;
            s7_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s2_valid_reg     <= pop;
            s3_valid_reg     <= s2_valid_reg;
            s4_valid_reg     <= s3_valid_reg;
            s5_valid_reg     <= s4_valid_reg;
            s6_valid_reg     <= s5_valid_reg;
            s7_valid_reg     <= s6_valid_reg;
            result_valid_reg <= s7_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_op_reg   <= head.op;
            s2_pos_reg  <= head.position;
            s2_mag_reg  <= sine_rom[m];
            s2_neg_reg  <= quad[1];

            s3_op_reg   <= s2_op_reg;
            s3_pos_reg  <= s2_pos_reg;
            s3_prod_reg <= prod;
            s3_neg_reg  <= s2_neg_reg;
            s3_hold_reg <= hold_rd;
            s3_prev_reg <= prev_rd;

            s4_op_reg   <= s3_op_reg;
            s4_err_reg  <= err;
            s4_am_reg   <= am;
            s4_dneg_reg <= dq[32];

            s5_op_reg   <= s4_op_reg;
            s5_pe_reg   <= pe;
            s5_hi_reg   <= d_hi;
            s5_lo_reg   <= d_lo;
            s5_dneg_reg <= s4_dneg_reg;

            s6_op_reg   <= s5_op_reg;
            s6_pe_reg   <= s5_pe_reg;
            s6_dmag_reg <= dmag;
            s6_dneg_reg <= s5_dneg_reg;

            s7_op_reg   <= s6_op_reg;
            s7_sum_reg  <= pd_sum;

            result_reg  <= res;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    `ASSERT_CLK(a_sat_at_rail,
        result_valid_reg && result_reg.saturated |->
            (result_reg.torque == TORQUE_MAX || result_reg.torque == TORQUE_MIN),
        "saturated flag without a rail torque")

endmodule

// File: rtl/joint_pd_with_sine_trajectory.sv
// top level of the joint pd controller with a sine trajectory on joint 0
//
// sample channel: sample_valid / sample_stall carry one joint sample (action,
// joint index, q16.16 position, q1.15 axis); an item is taken on a clock edge
// with valid high and stall low. result channel: result_valid / result_stall
// carry the torque and its saturation flag, exactly one result per sample, in
// order. cfg_we / cfg_index / cfg_data write the p gain, d gain per step,
// phase step, amplitude and deadzone registers; write them only while no item
// is in flight. a taken sample passes the queue and the back pipeline stages.
// throughput: one sample per cycle while result_stall is low, set by the back
// pipeline advancing one stage a cycle with the per-joint memories read and
// written at the pop. a four-entry queue parts the front from the back, so
// sample_stall rises only once the queue fills while result_stall holds the
// back pipeline. reset clears the phase, the queue and all valid flags and
// loads the register defaults; hold references and previous positions are
// not cleared, a joint must be captured before it is controlled.
module joint_pd_with_sine_trajectory import jpdst_pkg::*; (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [31:0]               cfg_data,
    input  logic                      sample_valid,
    output logic                      sample_stall,
    input  sample_t                   sample,
    output logic                      result_valid,
    input  logic                      result_stall,
    output result_t                   result
);

    cfg_t    cfg_reg;
    logic    push;
    qentry_t push_entry;
    logic    queue_full;
    logic    pop;
    qentry_t head;
    logic    head_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.p_gain          <= P_GAIN_RESET;
            cfg_reg.d_gain_per_step <= D_GAIN_PER_STEP_RESET;
            cfg_reg.phase_step      <= PHASE_STEP_RESET;
            cfg_reg.amplitude       <= AMPLITUDE_RESET;
            cfg_reg.deadzone        <= DEADZONE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_P_GAIN:          cfg_reg.p_gain          <= cfg_data[23:0];
                REG_D_GAIN_PER_STEP: cfg_reg.d_gain_per_step <= cfg_data;
                REG_PHASE_STEP:      cfg_reg.phase_step      <= cfg_data;
                REG_AMPLITUDE:       cfg_reg.amplitude       <= cfg_data[30:0];
                REG_DEADZONE:        cfg_reg.deadzone        <= cfg_data[14:0];
                default:             ;
            endcase
        end
    end

    jpdst_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .sample_valid (sample_valid),
        .sample       (sample),
        .sample_stall (sample_stall),
        .queue_full   (queue_full),
        .push         (push),
        .push_entry   (push_entry)
    );

    jpdst_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (queue_full),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid)
    );

    jpdst_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .head         (head),
        .head_valid   (head_valid),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule
